// ===== src/qdc_pkg.sv =====
// Shared types, control-store contents and the month length table for the calendar counter.
package qdc_pkg;

  localparam int unsigned PcW = 2;
  localparam int unsigned DayWorkW = 14;
  localparam int unsigned InW = 16;
  localparam logic [2:0] PhaseFirst = 3'd1;
  localparam logic [3:0] MonthFirst = 4'd1;
  localparam logic [3:0] MonthLast = 4'd12;
  localparam logic [3:0] MonthFeb = 4'd2;

  typedef logic [PcW-1:0] pc_t;

  // What the datapath does in the current step.
  typedef enum logic [1:0] {
    ACT_WAIT,
    ACT_START,
    ACT_MONTH,
    ACT_EMIT
  } act_e;

  // How the step counter moves on.
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_IN,
    JMP_DAY_GT,
    JMP_OUT_FREE
  } jmp_e;

  typedef struct packed {
    act_e act;
    jmp_e jmp;
    pc_t  target;
  } ucode_t;

  typedef struct packed {
    logic in_beat;
    logic in_pos;
    logic day_gt;
    logic out_free;
  } qdc_stat_t;

  typedef struct packed {
    act_e act;
  } qdc_ctrl_t;

  localparam pc_t PcWait = 2'd0;
  localparam pc_t PcStart = 2'd1;
  localparam pc_t PcMonth = 2'd2;
  localparam pc_t PcEmit = 2'd3;

  // The control store. A nonpositive beat skips straight to the result step.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PcWait:  w = '{act: ACT_WAIT,  jmp: JMP_IN,       target: PcEmit};
      PcStart: w = '{act: ACT_START, jmp: JMP_NEXT,     target: PcMonth};
      PcMonth: w = '{act: ACT_MONTH, jmp: JMP_DAY_GT,   target: PcMonth};
      PcEmit:  w = '{act: ACT_EMIT,  jmp: JMP_OUT_FREE, target: PcWait};
      default: w = '{act: ACT_WAIT,  jmp: JMP_ALWAYS,   target: PcWait};
    endcase
    return w;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MonthFeb:                                   len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/qdc_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module qdc_seq
  import qdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  qdc_stat_t stat_i,
  output qdc_ctrl_t ctrl_o
);

  pc_t    pc_q, pc_d;
  ucode_t word;

  assign word = ucode_rom(pc_q);
  assign ctrl_o.act = word.act;

  always_comb begin
    pc_d = pc_q;
    case (word.jmp)
      JMP_NEXT:   pc_d = pc_q + pc_t'(1);
      JMP_ALWAYS: pc_d = word.target;
      JMP_IN: begin
        if (stat_i.in_beat) begin
          pc_d = stat_i.in_pos ? pc_q + pc_t'(1) : word.target;
        end
      end
      JMP_DAY_GT: pc_d = stat_i.day_gt ? word.target : pc_q + pc_t'(1);
      JMP_OUT_FREE: begin
        if (stat_i.out_free) begin
          pc_d = word.target;
        end
      end
      default:    pc_d = PcWait;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcWait;
    end else begin
      pc_q <= pc_d;
    end
  end

  // The waiting step holds until a beat and the result step while the output register is full;
  // the month loop must leave once the day fits.
  a_loop_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.act == ACT_MONTH && !stat_i.day_gt) |=> (pc_q == PcEmit))
    else $error("month loop did not exit to the result step");

  a_skip_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.act == ACT_WAIT && stat_i.in_beat && !stat_i.in_pos) |=> (pc_q == PcEmit))
    else $error("nonpositive beat did not go straight to the result step");

  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word.act == ACT_EMIT && !stat_i.out_free) |=> (pc_q == PcEmit))
    else $error("result step left while the output register was full");

endmodule

// ===== src/quarter_day_calendar_counter.sv =====
// Top level of the quarter-day calendar counter: handshakes, calendar datapath, output register.
// A positive advance passes through the start step, one month step per month boundary crossed
// (one month per cycle, up to about 270 boundaries), and the result step, where the output loads.
// A zero or negative advance goes straight from the waiting step to the result step. One beat is
// in work at a time: no new beat is accepted until the result step has loaded the output register.
// Reset, asynchronous and active low, sets 1 January year 0, morning, and empties the output.
module quarter_day_calendar_counter
  import qdc_pkg::*;
#(
  parameter int unsigned YEAR_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] advance_quarters_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         day_phase_o,
  output logic [4:0]         day_of_month_o,
  output logic [3:0]         month_number_o,
  output logic [15:0]        year_number_o
);

  qdc_stat_t stat;
  qdc_ctrl_t ctrl;

  logic [2:0]           phase_q, phase_d;
  logic [4:0]           day_q, day_d;
  logic [3:0]           month_q, month_d;
  logic [YEAR_BITS-1:0] year_q, year_d;
  logic [InW-2:0]       adv_q, adv_d;
  logic [DayWorkW-1:0]  day_w_q, day_w_d;

  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_phase_q, out_phase_d;
  logic [4:0]           out_day_q, out_day_d;
  logic [3:0]           out_month_q, out_month_d;
  logic [15:0]          out_year_q, out_year_d;

  logic [4:0]           len;
  logic [InW:0]         total_m1;
  logic [DayWorkW-1:0]  day_sum;
  logic [YEAR_BITS+15:0] year_ext;

  qdc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  assign in_stall_o = (ctrl.act != ACT_WAIT);

  assign len = month_days(month_q, year_q[1:0] == 2'b00);
  // The phase is at least one, so subtracting one never wraps.
  assign total_m1 = {{(InW-2){1'b0}}, phase_q} + {2'b00, adv_q} - (InW+1)'(1);
  assign day_sum = {{(DayWorkW-5){1'b0}}, day_q} + total_m1[DayWorkW+1:2];
  assign year_ext = {16'b0, year_q};

  assign stat.in_beat = in_valid_i && !in_stall_o;
  assign stat.in_pos = (advance_quarters_i > 16'sd0);
  assign stat.day_gt = (day_w_q > {{(DayWorkW-5){1'b0}}, len});
  assign stat.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d = phase_q;
    day_d = day_q;
    month_d = month_q;
    year_d = year_q;
    adv_d = adv_q;
    day_w_d = day_w_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_phase_d = out_phase_q;
    out_day_d = out_day_q;
    out_month_d = out_month_q;
    out_year_d = out_year_q;
    case (ctrl.act)
      ACT_WAIT: begin
        if (stat.in_beat) begin
          adv_d = advance_quarters_i[InW-2:0];
          day_w_d = {{(DayWorkW-5){1'b0}}, day_q};
        end
      end
      ACT_START: begin
        phase_d = {1'b0, total_m1[1:0]} + PhaseFirst;
        day_w_d = day_sum;
      end
      ACT_MONTH: begin
        if (stat.day_gt) begin
          day_w_d = day_w_q - {{(DayWorkW-5){1'b0}}, len};
          if (month_q == MonthLast) begin
            month_d = MonthFirst;
            year_d = year_q + YEAR_BITS'(1);
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end
      ACT_EMIT: begin
        if (stat.out_free) begin
          day_d = day_w_q[4:0];
          out_valid_d = 1'b1;
          out_phase_d = phase_q;
          out_day_d = day_w_q[4:0];
          out_month_d = month_q;
          out_year_d = year_ext[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      day_q <= 5'd1;
      month_q <= MonthFirst;
      year_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      day_q <= day_d;
      month_q <= month_d;
      year_q <= year_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adv_q <= adv_d;
    day_w_q <= day_w_d;
    out_phase_q <= out_phase_d;
    out_day_q <= out_day_d;
    out_month_q <= out_month_d;
    out_year_q <= out_year_d;
  end

  assign out_valid_o = out_valid_q;
  assign day_phase_o = out_phase_q;
  assign day_of_month_o = out_day_q;
  assign month_number_o = out_month_q;
  assign year_number_o = out_year_q;

  a_day_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.act == ACT_EMIT) |-> (day_w_q != '0 && !stat.day_gt))
    else $error("day out of range for the month at the result step");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != 3'd0 && phase_q <= 3'd4))
    else $error("day phase out of range");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (month_q != 4'd0 && month_q <= MonthLast))
    else $error("month out of range");

  a_load_at_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(ctrl.act == ACT_EMIT))
    else $error("output register loaded outside the result step");

endmodule

// ===== test/quarter_day_calendar_counter_tb.sv =====
// Self-checking testbench for the quarter-day calendar counter.
module quarter_day_calendar_counter_tb
  import qdc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PHASES_PER_DAY = 4;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned YEAR_RUN_ITEMS = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES = 320;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [15:0] MAX_ADVANCE = 16'h7fff;
  localparam logic [15:0] MOST_NEGATIVE = 16'h8000;
  localparam logic [15:0] MINUS_ONE = 16'hffff;

  typedef struct packed {
    logic [2:0]  phase;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
  } calendar_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [15:0] advance_quarters_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         day_phase_o;
  logic [4:0]         day_of_month_o;
  logic [3:0]         month_number_o;
  logic [15:0]        year_number_o;

  // Predicted calendar, updated at each accepted beat.
  logic [2:0]  cal_phase = PhaseFirst;
  logic [4:0]  cal_day = 5'd1;
  logic [3:0]  cal_month = MonthFirst;
  logic [15:0] cal_year = 16'd0;
  calendar_t   pending_dates[$];

  logic in_idle_on = 1'b0;
  logic out_idle_on = 1'b0;
  int unsigned hold_len = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned advanced_count = 0;
  int unsigned ignored_count = 0;
  int unsigned wrap_count = 0;

  quarter_day_calendar_counter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .advance_quarters_i(advance_quarters_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .day_phase_o       (day_phase_o),
    .day_of_month_o    (day_of_month_o),
    .month_number_o    (month_number_o),
    .year_number_o     (year_number_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_dates.size());
      $display("quarter_day_calendar_counter_tb failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned days_in(input logic [3:0] month, input logic [15:0] year);
    case (month)
      MonthFeb:                return (year[1:0] == 2'd0) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: return 30;
      default:                 return 31;
    endcase
  endfunction

  // Moves the predicted calendar on by one beat and queues the date it should report.
  function automatic void step_calendar(input logic [15:0] quarters);
    int unsigned total;
    int unsigned day;
    int unsigned len;
    calendar_t   now;
    if (!quarters[15] && quarters != 16'd0) begin
      advanced_count++;
      total = int'(cal_phase) + int'(quarters) - 1;
      cal_phase = 3'(total % PHASES_PER_DAY + 1);
      day = int'(cal_day) + total / PHASES_PER_DAY;
      len = days_in(cal_month, cal_year);
      while (day > len) begin
        day -= len;
        if (cal_month == MonthLast) begin
          cal_month = MonthFirst;
          cal_year = cal_year + 16'd1;
          if (cal_year == 16'd0) wrap_count++;
        end else begin
          cal_month = cal_month + 4'd1;
        end
        len = days_in(cal_month, cal_year);
      end
      cal_day = 5'(day);
    end else begin
      ignored_count++;
    end
    now.phase = cal_phase;
    now.day = cal_day;
    now.month = cal_month;
    now.year = cal_year;
    pending_dates.push_back(now);
  endfunction

  task automatic send_advance(input logic [15:0] quarters);
    int unsigned gap;
    in_valid_i <= 1'b1;
    advance_quarters_i <= quarters;
    do @(posedge clk_i); while (in_stall_o);
    step_calendar(quarters);
    gap = (in_idle_on && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      advance_quarters_i <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_dates
    calendar_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_dates.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected, got %0d-%0d-%0d phase %0d", $time,
                 year_number_o, month_number_o, day_of_month_o, day_phase_o);
      end else begin
        want = pending_dates.pop_front();
        checked_count++;
        check_field("day_phase", 32'(want.phase), 32'(day_phase_o));
        check_field("day_of_month", 32'(want.day), 32'(day_of_month_o));
        check_field("month_number", 32'(want.month), 32'(month_number_o));
        check_field("year_number", 32'(want.year), 32'(year_number_o));
      end
    end
  end

  // Receiver stall: random stretches, or one long hold when a test asks for it.
  initial begin : receiver_stall
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_len != 0) begin
        stall_left = hold_len;
        hold_len <= 0;
      end else if (stall_left == 0 && out_idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic test_nonpositive();
    send_advance(16'd0);
    send_advance(MINUS_ONE);
    send_advance(MOST_NEGATIVE);
    send_advance(16'(-100));
  endtask

  // Morning through night and into the next day.
  task automatic test_phase_carry();
    repeat (4) send_advance(16'd1);
    send_advance(16'd2);
    send_advance(16'd3);
  endtask

  // Year 0 is a leap year, so February reaches the 29th before March.
  task automatic test_month_carry();
    send_advance(16'(4 * 30));
    send_advance(16'd4);
    send_advance(16'(4 * 28));
    send_advance(16'd4);
    send_advance(16'(4 * 300));
  endtask

  task automatic test_large_advance();
    send_advance(MAX_ADVANCE);
    send_advance(MAX_ADVANCE);
    send_advance(MINUS_ONE);
  endtask

  // The receiver holds off long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    in_idle_on <= 1'b0;
    out_idle_on <= 1'b0;
    hold_len <= HOLD_CYCLES;
    repeat (30) send_advance(16'($urandom_range(1, 40)));
  endtask

  task automatic test_random();
    int unsigned r;
    logic [15:0] quarters;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      // Every fourth stretch of 50 beats runs with no idling on either side.
      if (i % 50 == 0) begin
        in_idle_on <= ((i / 50) % 4 != 3);
        out_idle_on <= ((i / 50) % 4 != 3);
      end
      r = $urandom_range(0, 99);
      if (r < 35) quarters = 16'($urandom_range(1, 8));
      else if (r < 60) quarters = 16'($urandom_range(1, 400));
      else if (r < 72) quarters = 16'($urandom_range(400, 32767));
      else if (r < 82) quarters = 16'($urandom_range(32768, 65535));
      else if (r < 85) quarters = 16'd0;
      else quarters = 16'($urandom);
      send_advance(quarters);
    end
  endtask

  // A run of full-size advances that carries the year across several centuries.
  task automatic test_many_years();
    in_idle_on <= 1'b0;
    out_idle_on <= 1'b0;
    repeat (YEAR_RUN_ITEMS) send_advance(MAX_ADVANCE);
    repeat (4) send_advance(16'(4 * 15));
    send_advance(MAX_ADVANCE);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    advance_quarters_i = 16'd0;
    out_stall_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_nonpositive();
    test_phase_carry();
    test_month_carry();
    test_large_advance();
    test_backpressure();
    test_random();
    test_many_years();

    in_valid_i <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d advances and %0d zero or negative beats; %0d dates checked.",
             advanced_count, ignored_count, checked_count);
    $display("Year counter wrapped %0d time(s); last date %0d-%0d-%0d, phase %0d.",
             wrap_count, cal_year, cal_month, cal_day, cal_phase);
    if (error_count == 0) begin
      $display("quarter_day_calendar_counter_tb passed");
    end else begin
      $display("quarter_day_calendar_counter_tb failed");
    end
    $finish;
  end

endmodule
